// ===== sv/newton_reciprocal_divider_u32_core_defines.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the reciprocal divider
// each check can be compiled out as a group with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef NEWTON_RECIPROCAL_DIVIDER_U32_CORE_DEFINES_SVH
`define NEWTON_RECIPROCAL_DIVIDER_U32_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked check, quiet while reset is high
`define NRD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also runs through reset
`define NRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRD_ASSERT(lbl, clk, rst, prop, msg)
`define NRD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/nrd_pkg.sv =====
// ----------------------------------------------------------------------------
// nrd_pkg
// shared types, sequencer codes and seed tables of the reciprocal divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrd_pkg;

   // newton iterations on the reciprocal
   localparam int unsigned NEWTON_STEPS = 1;
   localparam int unsigned ITER_W       = $clog2(NEWTON_STEPS + 1);

   // leading zero search: halving steps of 16, 8, 4, 2, 1
   localparam int unsigned NORM_STEPS   = 5;
   localparam int unsigned NORM_CNT_W   = 3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_GUESS,
      S_XY,
      S_X2Y,
      S_PROD,
      S_SHIFT,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_LOAD,
      STEP_NORM,
      STEP_GUESS,
      STEP_XY,
      STEP_X2Y,
      STEP_PROD,
      STEP_SHIFT,
      STEP_OUT
   } step_type;

   typedef struct packed {
      step_type                step;
      logic [NORM_CNT_W-1:0]   norm_cnt;
      logic                    ready;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic special;
      logic lz_gt;
      logic out_free;
   } sts_type;

   // rounding numerator: twice 2^23
   localparam int unsigned TBL_N2 = 2 ** 24;

   // seed value round(2^23 / i) for i = 128..255, entry 0 is i = 128
   localparam int unsigned GUESS_VAL [128] = '{
      (TBL_N2 + 128) / (2 * 128), (TBL_N2 + 129) / (2 * 129), (TBL_N2 + 130) / (2 * 130),
      (TBL_N2 + 131) / (2 * 131), (TBL_N2 + 132) / (2 * 132), (TBL_N2 + 133) / (2 * 133),
      (TBL_N2 + 134) / (2 * 134), (TBL_N2 + 135) / (2 * 135), (TBL_N2 + 136) / (2 * 136),
      (TBL_N2 + 137) / (2 * 137), (TBL_N2 + 138) / (2 * 138), (TBL_N2 + 139) / (2 * 139),
      (TBL_N2 + 140) / (2 * 140), (TBL_N2 + 141) / (2 * 141), (TBL_N2 + 142) / (2 * 142),
      (TBL_N2 + 143) / (2 * 143), (TBL_N2 + 144) / (2 * 144), (TBL_N2 + 145) / (2 * 145),
      (TBL_N2 + 146) / (2 * 146), (TBL_N2 + 147) / (2 * 147), (TBL_N2 + 148) / (2 * 148),
      (TBL_N2 + 149) / (2 * 149), (TBL_N2 + 150) / (2 * 150), (TBL_N2 + 151) / (2 * 151),
      (TBL_N2 + 152) / (2 * 152), (TBL_N2 + 153) / (2 * 153), (TBL_N2 + 154) / (2 * 154),
      (TBL_N2 + 155) / (2 * 155), (TBL_N2 + 156) / (2 * 156), (TBL_N2 + 157) / (2 * 157),
      (TBL_N2 + 158) / (2 * 158), (TBL_N2 + 159) / (2 * 159), (TBL_N2 + 160) / (2 * 160),
      (TBL_N2 + 161) / (2 * 161), (TBL_N2 + 162) / (2 * 162), (TBL_N2 + 163) / (2 * 163),
      (TBL_N2 + 164) / (2 * 164), (TBL_N2 + 165) / (2 * 165), (TBL_N2 + 166) / (2 * 166),
      (TBL_N2 + 167) / (2 * 167), (TBL_N2 + 168) / (2 * 168), (TBL_N2 + 169) / (2 * 169),
      (TBL_N2 + 170) / (2 * 170), (TBL_N2 + 171) / (2 * 171), (TBL_N2 + 172) / (2 * 172),
      (TBL_N2 + 173) / (2 * 173), (TBL_N2 + 174) / (2 * 174), (TBL_N2 + 175) / (2 * 175),
      (TBL_N2 + 176) / (2 * 176), (TBL_N2 + 177) / (2 * 177), (TBL_N2 + 178) / (2 * 178),
      (TBL_N2 + 179) / (2 * 179), (TBL_N2 + 180) / (2 * 180), (TBL_N2 + 181) / (2 * 181),
      (TBL_N2 + 182) / (2 * 182), (TBL_N2 + 183) / (2 * 183), (TBL_N2 + 184) / (2 * 184),
      (TBL_N2 + 185) / (2 * 185), (TBL_N2 + 186) / (2 * 186), (TBL_N2 + 187) / (2 * 187),
      (TBL_N2 + 188) / (2 * 188), (TBL_N2 + 189) / (2 * 189), (TBL_N2 + 190) / (2 * 190),
      (TBL_N2 + 191) / (2 * 191), (TBL_N2 + 192) / (2 * 192), (TBL_N2 + 193) / (2 * 193),
      (TBL_N2 + 194) / (2 * 194), (TBL_N2 + 195) / (2 * 195), (TBL_N2 + 196) / (2 * 196),
      (TBL_N2 + 197) / (2 * 197), (TBL_N2 + 198) / (2 * 198), (TBL_N2 + 199) / (2 * 199),
      (TBL_N2 + 200) / (2 * 200), (TBL_N2 + 201) / (2 * 201), (TBL_N2 + 202) / (2 * 202),
      (TBL_N2 + 203) / (2 * 203), (TBL_N2 + 204) / (2 * 204), (TBL_N2 + 205) / (2 * 205),
      (TBL_N2 + 206) / (2 * 206), (TBL_N2 + 207) / (2 * 207), (TBL_N2 + 208) / (2 * 208),
      (TBL_N2 + 209) / (2 * 209), (TBL_N2 + 210) / (2 * 210), (TBL_N2 + 211) / (2 * 211),
      (TBL_N2 + 212) / (2 * 212), (TBL_N2 + 213) / (2 * 213), (TBL_N2 + 214) / (2 * 214),
      (TBL_N2 + 215) / (2 * 215), (TBL_N2 + 216) / (2 * 216), (TBL_N2 + 217) / (2 * 217),
      (TBL_N2 + 218) / (2 * 218), (TBL_N2 + 219) / (2 * 219), (TBL_N2 + 220) / (2 * 220),
      (TBL_N2 + 221) / (2 * 221), (TBL_N2 + 222) / (2 * 222), (TBL_N2 + 223) / (2 * 223),
      (TBL_N2 + 224) / (2 * 224), (TBL_N2 + 225) / (2 * 225), (TBL_N2 + 226) / (2 * 226),
      (TBL_N2 + 227) / (2 * 227), (TBL_N2 + 228) / (2 * 228), (TBL_N2 + 229) / (2 * 229),
      (TBL_N2 + 230) / (2 * 230), (TBL_N2 + 231) / (2 * 231), (TBL_N2 + 232) / (2 * 232),
      (TBL_N2 + 233) / (2 * 233), (TBL_N2 + 234) / (2 * 234), (TBL_N2 + 235) / (2 * 235),
      (TBL_N2 + 236) / (2 * 236), (TBL_N2 + 237) / (2 * 237), (TBL_N2 + 238) / (2 * 238),
      (TBL_N2 + 239) / (2 * 239), (TBL_N2 + 240) / (2 * 240), (TBL_N2 + 241) / (2 * 241),
      (TBL_N2 + 242) / (2 * 242), (TBL_N2 + 243) / (2 * 243), (TBL_N2 + 244) / (2 * 244),
      (TBL_N2 + 245) / (2 * 245), (TBL_N2 + 246) / (2 * 246), (TBL_N2 + 247) / (2 * 247),
      (TBL_N2 + 248) / (2 * 248), (TBL_N2 + 249) / (2 * 249), (TBL_N2 + 250) / (2 * 250),
      (TBL_N2 + 251) / (2 * 251), (TBL_N2 + 252) / (2 * 252), (TBL_N2 + 253) / (2 * 253),
      (TBL_N2 + 254) / (2 * 254), (TBL_N2 + 255) / (2 * 255)
   };

   // seed slope round(2^23 / (i * (i + 1))) for i = 128..255
   localparam int unsigned GUESS_SLP [128] = '{
      (TBL_N2 + 128 * 129) / (2 * 128 * 129), (TBL_N2 + 129 * 130) / (2 * 129 * 130),
      (TBL_N2 + 130 * 131) / (2 * 130 * 131), (TBL_N2 + 131 * 132) / (2 * 131 * 132),
      (TBL_N2 + 132 * 133) / (2 * 132 * 133), (TBL_N2 + 133 * 134) / (2 * 133 * 134),
      (TBL_N2 + 134 * 135) / (2 * 134 * 135), (TBL_N2 + 135 * 136) / (2 * 135 * 136),
      (TBL_N2 + 136 * 137) / (2 * 136 * 137), (TBL_N2 + 137 * 138) / (2 * 137 * 138),
      (TBL_N2 + 138 * 139) / (2 * 138 * 139), (TBL_N2 + 139 * 140) / (2 * 139 * 140),
      (TBL_N2 + 140 * 141) / (2 * 140 * 141), (TBL_N2 + 141 * 142) / (2 * 141 * 142),
      (TBL_N2 + 142 * 143) / (2 * 142 * 143), (TBL_N2 + 143 * 144) / (2 * 143 * 144),
      (TBL_N2 + 144 * 145) / (2 * 144 * 145), (TBL_N2 + 145 * 146) / (2 * 145 * 146),
      (TBL_N2 + 146 * 147) / (2 * 146 * 147), (TBL_N2 + 147 * 148) / (2 * 147 * 148),
      (TBL_N2 + 148 * 149) / (2 * 148 * 149), (TBL_N2 + 149 * 150) / (2 * 149 * 150),
      (TBL_N2 + 150 * 151) / (2 * 150 * 151), (TBL_N2 + 151 * 152) / (2 * 151 * 152),
      (TBL_N2 + 152 * 153) / (2 * 152 * 153), (TBL_N2 + 153 * 154) / (2 * 153 * 154),
      (TBL_N2 + 154 * 155) / (2 * 154 * 155), (TBL_N2 + 155 * 156) / (2 * 155 * 156),
      (TBL_N2 + 156 * 157) / (2 * 156 * 157), (TBL_N2 + 157 * 158) / (2 * 157 * 158),
      (TBL_N2 + 158 * 159) / (2 * 158 * 159), (TBL_N2 + 159 * 160) / (2 * 159 * 160),
      (TBL_N2 + 160 * 161) / (2 * 160 * 161), (TBL_N2 + 161 * 162) / (2 * 161 * 162),
      (TBL_N2 + 162 * 163) / (2 * 162 * 163), (TBL_N2 + 163 * 164) / (2 * 163 * 164),
      (TBL_N2 + 164 * 165) / (2 * 164 * 165), (TBL_N2 + 165 * 166) / (2 * 165 * 166),
      (TBL_N2 + 166 * 167) / (2 * 166 * 167), (TBL_N2 + 167 * 168) / (2 * 167 * 168),
      (TBL_N2 + 168 * 169) / (2 * 168 * 169), (TBL_N2 + 169 * 170) / (2 * 169 * 170),
      (TBL_N2 + 170 * 171) / (2 * 170 * 171), (TBL_N2 + 171 * 172) / (2 * 171 * 172),
      (TBL_N2 + 172 * 173) / (2 * 172 * 173), (TBL_N2 + 173 * 174) / (2 * 173 * 174),
      (TBL_N2 + 174 * 175) / (2 * 174 * 175), (TBL_N2 + 175 * 176) / (2 * 175 * 176),
      (TBL_N2 + 176 * 177) / (2 * 176 * 177), (TBL_N2 + 177 * 178) / (2 * 177 * 178),
      (TBL_N2 + 178 * 179) / (2 * 178 * 179), (TBL_N2 + 179 * 180) / (2 * 179 * 180),
      (TBL_N2 + 180 * 181) / (2 * 180 * 181), (TBL_N2 + 181 * 182) / (2 * 181 * 182),
      (TBL_N2 + 182 * 183) / (2 * 182 * 183), (TBL_N2 + 183 * 184) / (2 * 183 * 184),
      (TBL_N2 + 184 * 185) / (2 * 184 * 185), (TBL_N2 + 185 * 186) / (2 * 185 * 186),
      (TBL_N2 + 186 * 187) / (2 * 186 * 187), (TBL_N2 + 187 * 188) / (2 * 187 * 188),
      (TBL_N2 + 188 * 189) / (2 * 188 * 189), (TBL_N2 + 189 * 190) / (2 * 189 * 190),
      (TBL_N2 + 190 * 191) / (2 * 190 * 191), (TBL_N2 + 191 * 192) / (2 * 191 * 192),
      (TBL_N2 + 192 * 193) / (2 * 192 * 193), (TBL_N2 + 193 * 194) / (2 * 193 * 194),
      (TBL_N2 + 194 * 195) / (2 * 194 * 195), (TBL_N2 + 195 * 196) / (2 * 195 * 196),
      (TBL_N2 + 196 * 197) / (2 * 196 * 197), (TBL_N2 + 197 * 198) / (2 * 197 * 198),
      (TBL_N2 + 198 * 199) / (2 * 198 * 199), (TBL_N2 + 199 * 200) / (2 * 199 * 200),
      (TBL_N2 + 200 * 201) / (2 * 200 * 201), (TBL_N2 + 201 * 202) / (2 * 201 * 202),
      (TBL_N2 + 202 * 203) / (2 * 202 * 203), (TBL_N2 + 203 * 204) / (2 * 203 * 204),
      (TBL_N2 + 204 * 205) / (2 * 204 * 205), (TBL_N2 + 205 * 206) / (2 * 205 * 206),
      (TBL_N2 + 206 * 207) / (2 * 206 * 207), (TBL_N2 + 207 * 208) / (2 * 207 * 208),
      (TBL_N2 + 208 * 209) / (2 * 208 * 209), (TBL_N2 + 209 * 210) / (2 * 209 * 210),
      (TBL_N2 + 210 * 211) / (2 * 210 * 211), (TBL_N2 + 211 * 212) / (2 * 211 * 212),
      (TBL_N2 + 212 * 213) / (2 * 212 * 213), (TBL_N2 + 213 * 214) / (2 * 213 * 214),
      (TBL_N2 + 214 * 215) / (2 * 214 * 215), (TBL_N2 + 215 * 216) / (2 * 215 * 216),
      (TBL_N2 + 216 * 217) / (2 * 216 * 217), (TBL_N2 + 217 * 218) / (2 * 217 * 218),
      (TBL_N2 + 218 * 219) / (2 * 218 * 219), (TBL_N2 + 219 * 220) / (2 * 219 * 220),
      (TBL_N2 + 220 * 221) / (2 * 220 * 221), (TBL_N2 + 221 * 222) / (2 * 221 * 222),
      (TBL_N2 + 222 * 223) / (2 * 222 * 223), (TBL_N2 + 223 * 224) / (2 * 223 * 224),
      (TBL_N2 + 224 * 225) / (2 * 224 * 225), (TBL_N2 + 225 * 226) / (2 * 225 * 226),
      (TBL_N2 + 226 * 227) / (2 * 226 * 227), (TBL_N2 + 227 * 228) / (2 * 227 * 228),
      (TBL_N2 + 228 * 229) / (2 * 228 * 229), (TBL_N2 + 229 * 230) / (2 * 229 * 230),
      (TBL_N2 + 230 * 231) / (2 * 230 * 231), (TBL_N2 + 231 * 232) / (2 * 231 * 232),
      (TBL_N2 + 232 * 233) / (2 * 232 * 233), (TBL_N2 + 233 * 234) / (2 * 233 * 234),
      (TBL_N2 + 234 * 235) / (2 * 234 * 235), (TBL_N2 + 235 * 236) / (2 * 235 * 236),
      (TBL_N2 + 236 * 237) / (2 * 236 * 237), (TBL_N2 + 237 * 238) / (2 * 237 * 238),
      (TBL_N2 + 238 * 239) / (2 * 238 * 239), (TBL_N2 + 239 * 240) / (2 * 239 * 240),
      (TBL_N2 + 240 * 241) / (2 * 240 * 241), (TBL_N2 + 241 * 242) / (2 * 241 * 242),
      (TBL_N2 + 242 * 243) / (2 * 242 * 243), (TBL_N2 + 243 * 244) / (2 * 243 * 244),
      (TBL_N2 + 244 * 245) / (2 * 244 * 245), (TBL_N2 + 245 * 246) / (2 * 245 * 246),
      (TBL_N2 + 246 * 247) / (2 * 246 * 247), (TBL_N2 + 247 * 248) / (2 * 247 * 248),
      (TBL_N2 + 248 * 249) / (2 * 248 * 249), (TBL_N2 + 249 * 250) / (2 * 249 * 250),
      (TBL_N2 + 250 * 251) / (2 * 250 * 251), (TBL_N2 + 251 * 252) / (2 * 251 * 252),
      (TBL_N2 + 252 * 253) / (2 * 252 * 253), (TBL_N2 + 253 * 254) / (2 * 253 * 254),
      (TBL_N2 + 254 * 255) / (2 * 254 * 255), (TBL_N2 + 255 * 256) / (2 * 255 * 256)
   };

endpackage

// ===== sv/nrd_req_if.sv =====
// ----------------------------------------------------------------------------
// nrd_req_if
// operand channel: dividend and divisor with valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] dividend;
   logic [31:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// ===== sv/nrd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nrd_rsp_if
// result channel: quotient and divide by zero flag with valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] quotient;
   logic        divide_by_zero;

   modport source (output valid, output quotient, output divide_by_zero, input ready);
   modport sink   (input valid, input quotient, input divide_by_zero, output ready);
endinterface

// ===== sv/newton_reciprocal_divider_u32_core.sv =====
// ----------------------------------------------------------------------------
// newton_reciprocal_divider_u32_core
// approximate 32-bit unsigned divider through a newton refined reciprocal
//
// usage
//   req_ch takes one item of dividend and divisor when valid and ready are
//   both high; ready is high only while the sequencer is idle
//   rsp_ch returns one item per request: quotient and divide_by_zero
//   divisor zero gives an all-ones quotient with the flag set; zero dividend
//   gives zero; both go from the accept straight to the output load
//   a normal item runs a five-step leading zero search, a seed lookup,
//   two products per newton step, the final product, the shift and the
//   output load in that order, with the one multiplier in nrd_fxmul shared;
//   ready returns in the cycle after the output load, so the core takes
//   no new item before the last one has reached the output register
//   a result sits in the output register until rsp_ch.ready; the core may
//   already take and work on the next item, and holds its result until the
//   output register is free
//   synchronous reset empties the output register and returns the
//   sequencer to idle; payload registers keep their contents
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "newton_reciprocal_divider_u32_core_defines.svh"

module newton_reciprocal_divider_u32_core (
   input  logic          clock,
   input  logic          reset,
   nrd_req_if.sink       req_ch,
   nrd_rsp_if.source     rsp_ch
);

   nrd_pkg::ctl_type ctl;
   nrd_pkg::sts_type sts;

   // working registers
   logic [31:0] num_ff;
   logic [31:0] num_in;
   logic [31:0] den_ff;
   logic [31:0] den_in;
   logic [4:0]  zn_ff;
   logic [4:0]  zn_in;
   logic [4:0]  zd_ff;
   logic [4:0]  zd_in;
   logic [31:0] x_ff;
   logic [31:0] x_in;
   logic [31:0] p_ff;
   logic [31:0] p_in;
   logic [31:0] res_ff;
   logic [31:0] res_in;
   logic        dbz_ff;
   logic        dbz_in;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_q_ff;
   logic [31:0] rsp_q_in;
   logic        rsp_dbz_ff;
   logic        rsp_dbz_in;

   // shared unit and helpers
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] mul_p;
   logic [31:0] num_norm;
   logic [31:0] den_norm;
   logic [4:0]  zn_add;
   logic [4:0]  zd_add;
   logic [6:0]  seed_idx;
   logic [31:0] seed_val;
   logic [31:0] seed_slp;
   logic [31:0] dx;
   logic [31:0] corr;
   logic [4:0]  shamt;
   logic        out_free;
   logic        out_load;

   nrd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   nrd_norm_step u_norm_num (
      .cnt     (ctl.norm_cnt),
      .val     (num_ff),
      .val_out (num_norm),
      .add     (zn_add)
   );

   nrd_norm_step u_norm_den (
      .cnt     (ctl.norm_cnt),
      .val     (den_ff),
      .val_out (den_norm),
      .add     (zd_add)
   );

   nrd_fxmul u_mul (
      .a (mul_a),
      .b (mul_b),
      .p (mul_p)
   );

   // seed lookup, bit 31 of the normalized divisor is always set
   assign seed_idx = den_ff[30:24];
   assign seed_val = {nrd_pkg::GUESS_VAL[seed_idx][15:0], 16'h0000};
   assign seed_slp = {nrd_pkg::GUESS_SLP[seed_idx][15:0], 16'h0000};
   assign dx       = {den_ff[23:0], 8'h00};
   // no slope correction on an exact table point
   assign corr     = (dx == 32'h0) ? 32'h0 : mul_p;

   // right shift by 31 - (zd - zn)
   assign shamt    = ~(zd_ff - zn_ff);

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_load = (ctl.step == nrd_pkg::STEP_OUT) && out_free;

   always_comb begin
      sts.req_valid = req_ch.valid;
      sts.special   = (req_ch.divisor == 32'h0) || (req_ch.dividend == 32'h0);
      sts.lz_gt     = (zn_ff > zd_ff);
      sts.out_free  = out_free;
   end

   // multiplier operand select
   always_comb begin
      unique case (ctl.step)
         nrd_pkg::STEP_GUESS: begin
            mul_a = seed_slp;
            mul_b = dx;
         end
         nrd_pkg::STEP_XY: begin
            mul_a = x_ff;
            mul_b = den_ff;
         end
         nrd_pkg::STEP_X2Y: begin
            mul_a = x_ff;
            mul_b = p_ff;
         end
         nrd_pkg::STEP_PROD: begin
            mul_a = x_ff;
            mul_b = num_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = p_ff;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      zn_in  = zn_ff;
      zd_in  = zd_ff;
      x_in   = x_ff;
      p_in   = p_ff;
      res_in = res_ff;
      dbz_in = dbz_ff;
      unique case (ctl.step)
         nrd_pkg::STEP_LOAD: begin
            num_in = req_ch.dividend;
            den_in = req_ch.divisor;
            zn_in  = 5'd0;
            zd_in  = 5'd0;
            // zero result stays in place for a zero dividend or a too small one
            dbz_in = (req_ch.divisor == 32'h0);
            res_in = (req_ch.divisor == 32'h0) ? 32'hFFFF_FFFF : 32'h0;
         end
         nrd_pkg::STEP_NORM: begin
            num_in = num_norm;
            den_in = den_norm;
            zn_in  = zn_ff + zn_add;
            zd_in  = zd_ff + zd_add;
         end
         nrd_pkg::STEP_GUESS: begin
            x_in = seed_val - corr;
         end
         nrd_pkg::STEP_XY: begin
            p_in = mul_p;
         end
         nrd_pkg::STEP_X2Y: begin
            // x + (x - 2 * x * x * d)
            x_in = x_ff + (x_ff - {mul_p[30:0], 1'b0});
         end
         nrd_pkg::STEP_PROD: begin
            p_in = mul_p;
         end
         nrd_pkg::STEP_SHIFT: begin
            res_in = p_ff >> shamt;
         end
         default: begin
            num_in = num_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      zn_ff  <= zn_in;
      zd_ff  <= zd_in;
      x_ff   <= x_in;
      p_ff   <= p_in;
      res_ff <= res_in;
      dbz_ff <= dbz_in;
   end

   // output register
   always_comb begin
      rsp_q_in   = out_load ? res_ff : rsp_q_ff;
      rsp_dbz_in = out_load ? dbz_ff : rsp_dbz_ff;
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_q_ff   <= rsp_q_in;
      rsp_dbz_ff <= rsp_dbz_in;
   end

   assign req_ch.ready          = ctl.ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.quotient       = rsp_q_ff;
   assign rsp_ch.divide_by_zero = rsp_dbz_ff;

   // checks
   `NRD_ASSERT(a_dbz_all_ones, clock, reset,
      rsp_ch.valid && rsp_ch.divide_by_zero |-> rsp_ch.quotient == 32'hFFFF_FFFF,
      "divide by zero item without all-ones quotient")
   `NRD_ASSERT(a_busy_after_accept, clock, reset,
      req_ch.valid && req_ch.ready |=> !req_ch.ready,
      "ready high right after an accepted item")
   `NRD_ASSERT(a_norm_msb, clock, reset,
      ctl.step == nrd_pkg::STEP_XY |-> den_ff[31],
      "divisor not normalized at newton step")
   `NRD_ASSERT(a_prod_order, clock, reset,
      ctl.step == nrd_pkg::STEP_PROD |-> zn_ff <= zd_ff,
      "final product reached with dividend below divisor scale")

endmodule

// ===== sv/nrd_fxmul.sv =====
// ----------------------------------------------------------------------------
// nrd_fxmul
// shared 0.32 fixed point multiplier, word zero stands for 1.0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrd_fxmul (
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);

   logic [31:0] hh;
   logic [31:0] hl;
   logic [31:0] lh;
   logic [31:0] ll;
   logic [31:0] mid;
   logic [31:0] full;

   assign hh   = {16'h0000, a[31:16]} * {16'h0000, b[31:16]};
   assign hl   = {16'h0000, a[31:16]} * {16'h0000, b[15:0]};
   assign lh   = {16'h0000, a[15:0]}  * {16'h0000, b[31:16]};
   assign ll   = {16'h0000, a[15:0]}  * {16'h0000, b[15:0]};
   // middle sum wraps at 32 bits
   assign mid  = hl + lh;
   assign full = hh + {16'h0000, mid[31:16]} + {31'h0, ll[31]};

   always_comb begin
      priority if (a == 32'h0) begin
         p = b;
      end else if (b == 32'h0) begin
         p = a;
      end else begin
         p = full;
      end
   end

endmodule

// ===== sv/nrd_norm_step.sv =====
// ----------------------------------------------------------------------------
// nrd_norm_step
// one halving step of the leading zero search and left shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrd_norm_step (
   input  logic [nrd_pkg::NORM_CNT_W-1:0] cnt,
   input  logic [31:0]                    val,
   output logic [31:0]                    val_out,
   output logic [4:0]                     add
);

   always_comb begin
      val_out = val;
      add     = 5'd0;
      unique case (cnt)
         3'd0: begin
            if (val[31:16] == 16'h0) begin
               val_out = {val[15:0], 16'h0};
               add     = 5'd16;
            end
         end
         3'd1: begin
            if (val[31:24] == 8'h0) begin
               val_out = {val[23:0], 8'h0};
               add     = 5'd8;
            end
         end
         3'd2: begin
            if (val[31:28] == 4'h0) begin
               val_out = {val[27:0], 4'h0};
               add     = 5'd4;
            end
         end
         3'd3: begin
            if (val[31:30] == 2'b00) begin
               val_out = {val[29:0], 2'b00};
               add     = 5'd2;
            end
         end
         3'd4: begin
            if (!val[31]) begin
               val_out = {val[30:0], 1'b0};
               add     = 5'd1;
            end
         end
         default: begin
            val_out = val;
            add     = 5'd0;
         end
      endcase
   end

endmodule

// ===== sv/nrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrd_ctrl
// sequencer that walks one division through the shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  nrd_pkg::sts_type sts,
   output nrd_pkg::ctl_type ctl
);

   nrd_pkg::state_type                 state_ff;
   nrd_pkg::state_type                 state_in;
   logic [nrd_pkg::NORM_CNT_W-1:0]     norm_cnt_ff;
   logic [nrd_pkg::NORM_CNT_W-1:0]     norm_cnt_in;
   logic [nrd_pkg::ITER_W-1:0]         iter_ff;
   logic [nrd_pkg::ITER_W-1:0]         iter_in;
   logic                               norm_last;
   logic                               iter_last;

   assign norm_last = (norm_cnt_ff == nrd_pkg::NORM_CNT_W'(nrd_pkg::NORM_STEPS - 1));
   assign iter_last = (iter_ff == nrd_pkg::ITER_W'(nrd_pkg::NEWTON_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= nrd_pkg::S_IDLE;
         norm_cnt_ff <= '0;
         iter_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         norm_cnt_ff <= norm_cnt_in;
         iter_ff     <= iter_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nrd_pkg::S_IDLE: begin
            if (sts.req_valid) begin
               state_in = sts.special ? nrd_pkg::S_OUT : nrd_pkg::S_NORM;
            end
         end
         nrd_pkg::S_NORM: begin
            if (norm_last) begin
               state_in = nrd_pkg::S_GUESS;
            end
         end
         nrd_pkg::S_GUESS: begin
            state_in = sts.lz_gt ? nrd_pkg::S_OUT : nrd_pkg::S_XY;
         end
         nrd_pkg::S_XY: begin
            state_in = nrd_pkg::S_X2Y;
         end
         nrd_pkg::S_X2Y: begin
            state_in = iter_last ? nrd_pkg::S_PROD : nrd_pkg::S_XY;
         end
         nrd_pkg::S_PROD: begin
            state_in = nrd_pkg::S_SHIFT;
         end
         nrd_pkg::S_SHIFT: begin
            state_in = nrd_pkg::S_OUT;
         end
         nrd_pkg::S_OUT: begin
            if (sts.out_free) begin
               state_in = nrd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nrd_pkg::S_IDLE;
         end
      endcase
   end

   // step counters
   always_comb begin
      norm_cnt_in = norm_cnt_ff;
      iter_in     = iter_ff;
      unique case (state_ff)
         nrd_pkg::S_IDLE:  norm_cnt_in = '0;
         nrd_pkg::S_NORM:  norm_cnt_in = norm_cnt_ff + 1'b1;
         nrd_pkg::S_GUESS: iter_in     = '0;
         nrd_pkg::S_X2Y:   iter_in     = iter_ff + 1'b1;
         default: begin
            norm_cnt_in = norm_cnt_ff;
            iter_in     = iter_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl.ready    = (state_ff == nrd_pkg::S_IDLE);
      ctl.norm_cnt = norm_cnt_ff;
      unique case (state_ff)
         nrd_pkg::S_IDLE:  ctl.step = sts.req_valid ? nrd_pkg::STEP_LOAD : nrd_pkg::STEP_NONE;
         nrd_pkg::S_NORM:  ctl.step = nrd_pkg::STEP_NORM;
         nrd_pkg::S_GUESS: ctl.step = nrd_pkg::STEP_GUESS;
         nrd_pkg::S_XY:    ctl.step = nrd_pkg::STEP_XY;
         nrd_pkg::S_X2Y:   ctl.step = nrd_pkg::STEP_X2Y;
         nrd_pkg::S_PROD:  ctl.step = nrd_pkg::STEP_PROD;
         nrd_pkg::S_SHIFT: ctl.step = nrd_pkg::STEP_SHIFT;
         nrd_pkg::S_OUT:   ctl.step = nrd_pkg::STEP_OUT;
         default:          ctl.step = nrd_pkg::STEP_NONE;
      endcase
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives operand pairs into the reciprocal divider under random handshake
// pressure on both channels, predicts every quotient and divide by zero flag
// with a bit-true model of the seed table, newton step and partial product
// multiplier, and compares each returned item in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   // run ends here even if the block hangs
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_ITEMS = 1100;
   // cycles allowed after the last expected item
   localparam int unsigned DRAIN_CYCLES = 40;

   typedef struct {
      logic [31:0] dividend;
      logic [31:0] divisor;
      logic [31:0] quotient;
      logic        divide_by_zero;
   } division_type;

   // ------------------------------------------------------------------------
   // quotient scoreboard: predicts each accepted operand pair and matches
   // returned items against the oldest prediction
   // ------------------------------------------------------------------------
   class quotient_scoreboard;
      division_type pending_quotients[$];
      int           errors = 0;

      // number of leading zeros, 32 for zero
      function logic [5:0] leading_zeros(logic [31:0] v);
         logic [5:0] n;
         n = 6'd32;
         for (int b = 0; b < 32; b++)
            if (v[b]) n = 6'(31 - b);
         return n;
      endfunction

      // unsigned fraction multiply on 16x16 partial products, zero means 1.0
      function logic [31:0] frac_mul(logic [31:0] a, logic [31:0] b);
         logic [31:0] ah, al, bh, bl, mid, low;
         if (a == 32'd0) return b;
         if (b == 32'd0) return a;
         ah  = a >> 16;
         al  = a & 32'h0000_FFFF;
         bh  = b >> 16;
         bl  = b & 32'h0000_FFFF;
         mid = ah * bl + al * bh;
         low = al * bl;
         return ah * bh + (mid >> 16) + (low >> 31);
      endfunction

      // table seed of 0.5 / x: value minus slope times the offset in the segment
      function logic [31:0] reciprocal_seed(logic [31:0] x);
         logic [63:0] seg, span, t;
         logic [31:0] val, slp, dx, corr;
         seg = 64'(x[31:24]);
         if (seg < 64'h80) seg = 64'h80;
         t    = (64'd16777216 + seg) / (64'd2 * seg);
         val  = {t[15:0], 16'h0000};
         span = seg * (seg + 64'd1);
         t    = (64'd16777216 + span) / (64'd2 * span);
         slp  = {t[15:0], 16'h0000};
         dx   = x << 8;
         corr = (dx == 32'd0) ? 32'd0 : frac_mul(slp, dx);
         return val - corr;
      endfunction

      function division_type reciprocal_quotient(logic [31:0] num, logic [31:0] den);
         division_type r;
         logic [5:0]   zn, zd;
         logic [4:0]   sh;
         logic [31:0]  nn, dn, recip, xy, x2y, prod;
         r.dividend       = num;
         r.divisor        = den;
         r.divide_by_zero = (den == 32'd0);
         r.quotient       = 32'hFFFF_FFFF;
         if (den != 32'd0) begin
            zn = leading_zeros(num);
            zd = leading_zeros(den);
            if (zn > zd) begin
               r.quotient = 32'd0;
            end else begin
               sh    = 5'(zd - zn);
               nn    = num << zn[4:0];
               dn    = den << zd[4:0];
               recip = reciprocal_seed(dn);
               for (int k = 0; k < nrd_pkg::NEWTON_STEPS; k++) begin
                  xy    = frac_mul(recip, dn);
                  x2y   = frac_mul(recip, xy);
                  recip = recip + (recip - (x2y << 1));
               end
               prod       = frac_mul(recip, nn);
               r.quotient = prod >> (5'd31 - sh);
            end
         end
         return r;
      endfunction

      function void note_operands(logic [31:0] num, logic [31:0] den);
         pending_quotients.push_back(reciprocal_quotient(num, den));
      endfunction

      function void check_result(logic [31:0] quotient, logic divide_by_zero);
         division_type e;
         if (pending_quotients.size() == 0) begin
            $display("%0t: unexpected item, actual quotient %h divide_by_zero %b",
                     $time, quotient, divide_by_zero);
            errors++;
            return;
         end
         e = pending_quotients.pop_front();
         if (quotient !== e.quotient) begin
            $display("%0t: %h / %h quotient expected %h actual %h",
                     $time, e.dividend, e.divisor, e.quotient, quotient);
            errors++;
         end
         if (divide_by_zero !== e.divide_by_zero) begin
            $display("%0t: %h / %h divide_by_zero expected %b actual %b",
                     $time, e.dividend, e.divisor, e.divide_by_zero, divide_by_zero);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_quotients.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   // while set, neither side idles: items go in as fast as the block takes them
   bit          steady = 1'b0;
   int unsigned cycles = 0;

   quotient_scoreboard board = new();

   nrd_req_if req_ch ();
   nrd_rsp_if rsp_ch ();

   newton_reciprocal_divider_u32_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // hard stop on a hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("newton_reciprocal_divider_u32_core: mismatch");
         $finish;
      end
   end

   // watch both channels; values read here are the ones from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_operands(req_ch.dividend, req_ch.divisor);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.quotient, rsp_ch.divide_by_zero);
      end
   end

   // result side: stall about a quarter of the cycles, never in the steady stretch
   initial begin : rsp_side
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && (steady || $urandom_range(99) >= 25);
      end
   end

   // present one operand pair, with random idle cycles first, and hold it
   // until the block takes it; returns at the accepting edge, where ready is seen high
   task automatic send_operands(input logic [31:0] num, input logic [31:0] den);
      while (!steady && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.dividend <= num;
      req_ch.divisor  <= den;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] num, den;
      int unsigned zn, zd, pick;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.dividend <= 32'd0;
      req_ch.divisor  <= 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // divide by zero, with zero, small and full dividends
      send_operands(32'h0000_0000, 32'h0000_0000);
      send_operands(32'hFFFF_FFFF, 32'h0000_0000);
      send_operands(32'h0000_1234, 32'h0000_0000);
      // zero dividend gives zero
      send_operands(32'h0000_0000, 32'h0000_0001);
      send_operands(32'h0000_0000, 32'hFFFF_FFFF);
      // extremes of both fields
      send_operands(32'h0000_0001, 32'h0000_0001);
      send_operands(32'hFFFF_FFFF, 32'h0000_0001);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'h8000_0000, 32'h0000_0001);
      // dividend with more leading zeros than the divisor
      send_operands(32'h0000_0001, 32'hFFFF_FFFF);
      send_operands(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'h5555_5555, 32'hAAAA_AAAA);
      // power of two divisors: first segment, seed value wraps to 1.0
      send_operands(32'h8000_0000, 32'h8000_0000);
      send_operands(32'hFFFF_FFFF, 32'h8000_0000);
      send_operands(32'hFFFF_FFFF, 32'h0000_0002);
      // segment offset zero, no slope correction
      send_operands(32'h1234_5678, 32'h0100_0000);
      send_operands(32'hFFFF_FFFF, 32'hFF00_0000);
      // ordinary operands across the range
      send_operands(32'hFFFF_FFFF, 32'h0000_0003);
      send_operands(32'hFFFF_FFFF, 32'h0000_0007);
      send_operands(32'h0000_0100, 32'h0000_0010);
      send_operands(32'hDEAD_BEEF, 32'h0000_1234);
      send_operands(32'h0000_1000, 32'h0000_0007);
      send_operands(32'hAAAA_AAAA, 32'h5555_5555);
      send_operands(32'hFFFF_FFFF, 32'h00FF_FFFF);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 500 && n < 700);
         // mostly dividends no shorter than the divisor, so the full
         // newton path runs; the rest covers the zero shortcut
         zd = $urandom_range(31);
         zn = ($urandom_range(99) < 85) ? $urandom_range(zd) : $urandom_range(31);
         num = {1'b1, 31'($urandom)} >> zn;
         den = {1'b1, 31'($urandom)} >> zd;
         pick = $urandom_range(99);
         if (pick < 5)
            den = 32'd0;
         else if (pick < 13)
            den = {8'($urandom_range(255)), 24'h00_0000} >> $urandom_range(31);
         else if (pick < 18)
            den = 32'd1 << $urandom_range(31);
         else if (pick < 22)
            num = 32'd0;
         else if (pick < 30)
            num = $urandom;
         send_operands(num, den);
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.outstanding() == 0)
         $display("newton_reciprocal_divider_u32_core: match");
      else
         $display("newton_reciprocal_divider_u32_core: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/nrd_pkg.sv
sv/nrd_req_if.sv
sv/nrd_rsp_if.sv
sv/nrd_fxmul.sv
sv/nrd_norm_step.sv
sv/nrd_ctrl.sv
sv/newton_reciprocal_divider_u32_core.sv
tb/testbench.sv
